// File: design/srsw_pkg.sv
// shared types and constants for the selective-repeat sender window
// no dependencies; imported by every module of the block
package srsw_pkg;

    // field widths of the input and result transfers
    localparam int SEQ_W      = 32;
    localparam int AGE_W      = 16;
    localparam int FLIGHT_W   = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int KIND_W     = 3;
    localparam int OP_W       = 2;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 80;
    localparam int M_PAD_W    = M_DATA_W - (SEQ_W + SLOT_OUT_W + SEQ_W + FLIGHT_W);

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;
    localparam logic [AGE_W-1:0]    TIMEOUT_RST = 16'd1000;
    localparam logic [FLIGHT_W-1:0] WINDOW_RST  = 5'd10;
    localparam int WINDOW_CAP = 16;

    // ack check unit: crc-32 and slot remainder, four bits a step
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam int          CHK_STEPS = 8;
    localparam int          CHK_CNT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_SENT    = 3'd0,
        K_FULL    = 3'd1,
        K_ACK_OK  = 3'd2,
        K_ACK_BAD = 3'd3,
        K_ACK_OUT = 3'd4,
        K_RETX    = 3'd5,
        K_IDLE    = 3'd6
    } kind_t;

    // which sequence number a result reports
    typedef enum logic [1:0] {
        SRC_NEXT = 2'd0,
        SRC_ACK  = 2'd1,
        SRC_HELD = 2'd2,
        SRC_BASE = 2'd3
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND,
        ST_CHK,
        ST_ACK_DEC,
        ST_SLIDE,
        ST_TK_RD,
        ST_TK_EV,
        ST_TK_END
    } state_t;

    typedef struct packed {
        logic  load;
        logic  chk_start;
        logic  send_do;
        logic  ack_mark;
        logic  slide;
        logic  tick_rd;
        logic  tick_ev;
        logic  emit;
        logic  emit_last;
        src_t  emit_src;
        kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic out_free;
        logic has_room;
        logic chk_done;
        logic crc_ok;
        logic in_win;
        logic slide_ok;
        logic scan_end;
        logic age_hit;
        logic held_valid;
    } status_t;

endpackage

// File: design/srsw_ackchk.sv
// ack check unit: crc-32 of the ack number and its slot remainder
// runs four bits a cycle; uses srsw_pkg
module srsw_ackchk #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [srsw_pkg::SEQ_W-1:0] number,
    input  logic [31:0]                crc_in,
    output logic                       done,
    output logic                       crc_ok,
    output logic [$clog2(DEPTH)-1:0]   slot
);
    import srsw_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int VW = SW + 4;

    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          exp_reg;
    logic [SEQ_W-1:0]     lo_sh_reg;
    logic [SEQ_W-1:0]     hi_sh_reg;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [CHK_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // reflected crc, bits taken from bit 0 upward
    always_comb begin
        logic [31:0] c;
        c = crc_reg ^ {28'd0, lo_sh_reg[3:0]};
        for (int b = 0; b < 4; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_next = c;
    end

    // remainder by the window depth, nibble at a time from the top
    always_comb begin
        logic [VW-1:0] v;
        v = {rem_reg, hi_sh_reg[SEQ_W-1 -: 4]};
        for (int i = 3; i >= 0; i--) begin
            if (v >= (VW'(DEPTH) << i)) begin
                v = v - (VW'(DEPTH) << i);
            end
        end
        rem_next = v[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CHK_CNT_W'(CHK_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            crc_reg   <= CRC_INIT;
            exp_reg   <= crc_in;
            lo_sh_reg <= number;
            hi_sh_reg <= number;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            crc_reg   <= crc_next;
            lo_sh_reg <= lo_sh_reg >> 4;
            hi_sh_reg <= hi_sh_reg << 4;
            rem_reg   <= rem_next;
        end
    end

    assign done   = done_reg;
    assign crc_ok = ((crc_reg ^ CRC_INIT) == exp_reg);
    assign slot   = rem_reg;

endmodule

// File: design/srsw_dp.sv
// datapath of the sender window: sequence state, slot ack bits, age memory,
// configuration registers and the result register; uses srsw_pkg, srsw_ackchk
module srsw_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  srsw_pkg::cmd_t                  cmd,
    output srsw_pkg::status_t               status,
    input  logic [srsw_pkg::OP_W-1:0]       s_tuser,
    input  logic [srsw_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic                            m_tlast,
    output logic [srsw_pkg::KIND_W-1:0]     m_tuser,
    output logic [srsw_pkg::M_DATA_W-1:0]   m_tdata
);
    import srsw_pkg::*;

    localparam int SW   = $clog2(DEPTH);
    localparam int WMAX = (DEPTH < WINDOW_CAP) ? DEPTH : WINDOW_CAP;
    localparam logic [SW-1:0] SLOT_LAST = SW'(DEPTH - 1);

    logic [AGE_W-1:0]    timeout_reg;
    logic [FLIGHT_W-1:0] window_reg;
    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SEQ_W-1:0]    next_reg;
    logic [FLIGHT_W-1:0] flight_reg, flight_next;
    logic [SW-1:0]       base_slot_reg, next_slot_reg;
    logic [SEQ_W-1:0]    cur_seq_reg;
    logic [SW-1:0]       cur_slot_reg;
    logic [FLIGHT_W-1:0] scan_left_reg;
    logic                held_valid_reg;
    logic [SEQ_W-1:0]    held_seq_reg;
    logic [SW-1:0]       held_slot_reg;
    logic [SEQ_W-1:0]    ackn_reg;
    logic [DEPTH-1:0]    acked_reg;
    logic [AGE_W-1:0]    age_mem [DEPTH];
    logic [AGE_W-1:0]    age_q_reg;

    logic                out_valid_reg;
    logic                out_last_reg;
    kind_t               out_kind_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [SEQ_W-1:0]    out_base_reg;
    logic [FLIGHT_W-1:0] out_flight_reg;

    logic                chk_done, chk_crc_ok;
    logic [SW-1:0]       chk_slot;
    logic [FLIGHT_W-1:0] eff_win;
    logic [AGE_W-1:0]    lim, age_inc;
    logic                out_free;
    logic [SW-1:0]       next_slot_inc, base_slot_inc, cur_slot_inc;
    logic [SEQ_W-1:0]    sel_seq;
    logic [SW-1:0]       sel_slot;
    logic [SLOT_OUT_W-1:0] sel_slot4;
    logic                age_we;
    logic [SW-1:0]       age_waddr;
    logic [AGE_W-1:0]    age_wdata;

    srsw_ackchk #(.DEPTH(DEPTH)) u_ackchk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.chk_start),
        .number  (s_tdata[SEQ_W-1:0]),
        .crc_in  (s_tdata[S_DATA_W-1:SEQ_W]),
        .done    (chk_done),
        .crc_ok  (chk_crc_ok),
        .slot    (chk_slot)
    );

    // window clamp and timeout floor
    always_comb begin
        eff_win = (window_reg == '0) ? FLIGHT_W'(1) : window_reg;
        if (eff_win > FLIGHT_W'(WMAX)) begin
            eff_win = FLIGHT_W'(WMAX);
        end
        lim     = (timeout_reg == '0) ? AGE_W'(1) : timeout_reg;
        age_inc = (age_q_reg == {AGE_W{1'b1}}) ? age_q_reg : age_q_reg + 1'b1;
    end

    assign next_slot_inc = (next_slot_reg == SLOT_LAST) ? '0 : next_slot_reg + 1'b1;
    assign base_slot_inc = (base_slot_reg == SLOT_LAST) ? '0 : base_slot_reg + 1'b1;
    assign cur_slot_inc  = (cur_slot_reg == SLOT_LAST) ? '0 : cur_slot_reg + 1'b1;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        status            = '0;
        status.in_op      = op_t'(s_tuser);
        status.out_free   = out_free;
        status.has_room   = (flight_reg < eff_win);
        status.chk_done   = chk_done;
        status.crc_ok     = chk_crc_ok;
        status.in_win     = ((ackn_reg - base_reg) < {{(SEQ_W-FLIGHT_W){1'b0}}, flight_reg});
        status.slide_ok   = (flight_reg != '0) && acked_reg[base_slot_reg];
        status.scan_end   = (scan_left_reg == '0);
        status.age_hit    = !acked_reg[cur_slot_reg] && (age_inc >= lim);
        status.held_valid = held_valid_reg;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            window_reg  <= WINDOW_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_WINDOW:  window_reg  <= cfg_wdata[FLIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequence state
    always_comb begin
        base_next   = cmd.slide ? base_reg + 1'b1 : base_reg;
        flight_next = flight_reg;
        if (cmd.send_do) begin
            flight_next = flight_reg + 1'b1;
        end else if (cmd.slide) begin
            flight_next = flight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            next_reg      <= '0;
            flight_reg    <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            acked_reg     <= '0;
        end else begin
            base_reg   <= base_next;
            flight_reg <= flight_next;
            if (cmd.send_do) begin
                next_reg                 <= next_reg + 1'b1;
                next_slot_reg            <= next_slot_inc;
                acked_reg[next_slot_reg] <= 1'b0;
            end
            if (cmd.ack_mark) begin
                acked_reg[chk_slot] <= 1'b1;
            end
            if (cmd.slide) begin
                base_slot_reg            <= base_slot_inc;
                acked_reg[base_slot_reg] <= 1'b0;
            end
        end
    end

    // scan cursor and the retransmit held back until the next one is known
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            scan_left_reg  <= '0;
        end else if (cmd.load) begin
            held_valid_reg <= 1'b0;
            scan_left_reg  <= flight_reg;
        end else if (cmd.tick_ev) begin
            scan_left_reg <= scan_left_reg - 1'b1;
            if (status.age_hit) begin
                held_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_seq_reg  <= base_reg;
            cur_slot_reg <= base_slot_reg;
            ackn_reg     <= s_tdata[SEQ_W-1:0];
        end else if (cmd.tick_ev) begin
            cur_seq_reg  <= cur_seq_reg + 1'b1;
            cur_slot_reg <= cur_slot_inc;
            if (status.age_hit) begin
                held_seq_reg  <= cur_seq_reg;
                held_slot_reg <= cur_slot_reg;
            end
        end
    end

    // age memory, one write and one registered read a cycle
    always_comb begin
        age_we    = 1'b0;
        age_waddr = next_slot_reg;
        age_wdata = '0;
        if (cmd.send_do) begin
            age_we = 1'b1;
        end else if (cmd.tick_ev && !acked_reg[cur_slot_reg]) begin
            age_we    = 1'b1;
            age_waddr = cur_slot_reg;
            age_wdata = status.age_hit ? '0 : age_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (age_we) begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (cmd.tick_rd) begin
            age_q_reg <= age_mem[cur_slot_reg];
        end
    end

    // result register
    always_comb begin
        logic [SW+SLOT_OUT_W-1:0] slot_wide;
        case (cmd.emit_src)
            SRC_NEXT: begin
                sel_seq  = next_reg;
                sel_slot = next_slot_reg;
            end
            SRC_ACK: begin
                sel_seq  = ackn_reg;
                sel_slot = chk_slot;
            end
            SRC_HELD: begin
                sel_seq  = held_seq_reg;
                sel_slot = held_slot_reg;
            end
            default: begin
                sel_seq  = base_reg;
                sel_slot = base_slot_reg;
            end
        endcase
        slot_wide = {{SLOT_OUT_W{1'b0}}, sel_slot};
        sel_slot4 = slot_wide[SLOT_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg   <= cmd.emit_kind;
            out_last_reg   <= cmd.emit_last;
            out_seq_reg    <= sel_seq;
            out_slot_reg   <= sel_slot4;
            out_base_reg   <= base_next;
            out_flight_reg <= flight_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_flight_reg, out_base_reg, out_slot_reg,
                       out_seq_reg};

`ifndef SYNTH
    a_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        flight_reg <= FLIGHT_W'(WMAX))
        else $error("packets in flight beyond the window depth");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result loaded over one not yet taken");
    a_slide_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slide |-> (flight_reg != '0) && acked_reg[base_slot_reg])
        else $error("base slid over an unacked or empty window");
    a_send_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.send_do |=> flight_reg == $past(flight_reg) + 1'b1)
        else $error("send did not raise the in-flight count");
`endif

endmodule

// File: design/srsw_ctrl.sv
// controller of the sender window: sequences each input over the datapath
// issues commands and reads status only; uses srsw_pkg
module srsw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srsw_pkg::status_t   status,
    output srsw_pkg::cmd_t      cmd
);
    import srsw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (status.in_op)
                        OP_SEND: state_next = ST_SEND;
                        OP_ACK: begin
                            cmd.chk_start = 1'b1;
                            state_next    = ST_CHK;
                        end
                        OP_TICK: state_next = ST_TK_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEND: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_src  = SRC_NEXT;
                    cmd.send_do   = status.has_room;
                    cmd.emit_kind = status.has_room ? K_SENT : K_FULL;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (status.chk_done) begin
                    state_next = ST_ACK_DEC;
                end
            end
            ST_ACK_DEC: begin
                if (status.crc_ok && status.in_win) begin
                    cmd.ack_mark = 1'b1;
                    state_next   = ST_SLIDE;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_src  = SRC_ACK;
                    cmd.emit_kind = status.crc_ok ? K_ACK_OUT : K_ACK_BAD;
                    state_next    = ST_IDLE;
                end
            end
            ST_SLIDE: begin
                if (status.slide_ok) begin
                    cmd.slide = 1'b1;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_src  = SRC_ACK;
                    cmd.emit_kind = K_ACK_OK;
                    state_next    = ST_IDLE;
                end
            end
            ST_TK_RD: begin
                if (status.scan_end) begin
                    state_next = ST_TK_END;
                end else begin
                    cmd.tick_rd = 1'b1;
                    state_next  = ST_TK_EV;
                end
            end
            ST_TK_EV: begin
                if (status.age_hit && status.held_valid) begin
                    if (status.out_free) begin
                        cmd.tick_ev   = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b0;
                        cmd.emit_src  = SRC_HELD;
                        cmd.emit_kind = K_RETX;
                        state_next    = ST_TK_RD;
                    end
                end else begin
                    cmd.tick_ev = 1'b1;
                    state_next  = ST_TK_RD;
                end
            end
            ST_TK_END: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_src  = status.held_valid ? SRC_HELD : SRC_BASE;
                    cmd.emit_kind = status.held_valid ? K_RETX : K_IDLE;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/selective_repeat_sender_window.sv
// selective-repeat sender window, top level: controller plus datapath
// depends on srsw_pkg, srsw_ctrl, srsw_dp (which holds srsw_ackchk)
//
// Sender side of a selective-repeat ARQ. Each input transfer carries an op on
// s_tuser: a send request takes the next sequence number while the count in
// flight is below window_in_use (clamped to 1..min(WINDOW_DEPTH,16)), an ack
// is checked against its CRC-32 (zlib style, over the number's four
// little-endian bytes) and, when good and inside [base, next), marks its slot
// and slides the base over acked slots; a tick ages every unacked slot in the
// window and reports a retransmit, in sequence order, for each slot whose age
// reaches timeout_ticks. Every input yields one or more result transfers, the
// final one flagged by m_tlast; op 3 yields none. One input is worked on at
// a time: a send is taken and then answered; an ack goes through the ack check
// unit (4 bits a cycle), is decided and, when good, releases its acked slots
// one at a time before its result; a tick reads and then ages each slot in
// flight in turn, since the age memory has one registered read port, then
// gives its final result; result-side stalls add to each. A new input is taken
// while the previous result still waits in the output register. The age
// memory needs no clearing pass: an age is written when its slot is sent.
module selective_repeat_sender_window #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srsw_pkg::OP_W-1:0]       s_tuser,   // op
    input  logic [srsw_pkg::S_DATA_W-1:0]   s_tdata,   // ack_number, ack_crc
    // configuration writes
    input  logic                            cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index, // 0 timeout_ticks, 1 window_in_use
    input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tlast,
    output logic [srsw_pkg::KIND_W-1:0]     m_tuser,   // kind
    output logic [srsw_pkg::M_DATA_W-1:0]   m_tdata    // seq, slot, base_seq, in_flight, zero pad
);
    import srsw_pkg::*;

    cmd_t    cmd;
    status_t status;

    // state machine that steps each transfer through the datapath
    srsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // window state, ack check, age memory and result register
    srsw_dp #(.DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

// File: test/srsw_tb_pkg.sv
// testbench helpers for the selective-repeat sender window
// no dependencies; imported by the checker and the testbench top
package srsw_tb_pkg;

    // crc-32 of a word sent as four little-endian bytes, reflected form
    function automatic logic [31:0] crc32_word(input logic [31:0] w);
        logic [31:0] c;
        logic        fb;
        c = 32'hFFFF_FFFF;
        for (int i = 0; i < 32; i++) begin
            fb = c[0] ^ w[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 32'hEDB8_8320;
            end
        end
        return ~c;
    endfunction

endpackage

// File: test/srsw_checker.sv
// checker for the selective-repeat sender window: mirrors the window state,
// predicts results per accepted input and compares them in order
// depends on srsw_pkg and srsw_tb_pkg
module srsw_checker #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [srsw_pkg::OP_W-1:0]       s_tuser,
    input  logic [srsw_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            m_tlast,
    input  logic [srsw_pkg::KIND_W-1:0]     m_tuser,
    input  logic [srsw_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              fail_count,
    output int                              pending,
    output logic [31:0]                     win_base,
    output logic [31:0]                     win_next
);
    import srsw_pkg::*;
    import srsw_tb_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [31:0] seq;
        logic [3:0]  slot;
        logic [31:0] base;
        logic [4:0]  flight;
        logic        last;
    } report_t;

    report_t     awaited_reports[$];
    report_t     burst[$];
    logic [31:0] base_q;
    logic [31:0] next_q;
    logic        pend[DEPTH];
    logic        acked[DEPTH];
    logic [15:0] age[DEPTH];
    logic [15:0] timeout_reg;
    logic [4:0]  window_reg;
    int          fails;

    function automatic int slot_idx(logic [31:0] s);
        return int'(s % DEPTH);
    endfunction

    task automatic note(kind_t k, logic [31:0] s);
        report_t r;
        r.kind   = k;
        r.seq    = s;
        r.slot   = 4'(slot_idx(s));
        r.base   = base_q;
        r.flight = 5'(next_q - base_q);
        r.last   = 1'b0;
        burst.push_back(r);
    endtask

    // advance the mirrored window by one input and queue what it reports
    task automatic advance_window(op_t op, logic [31:0] num, logic [31:0] crc);
        int          k;
        int          eff;
        logic [31:0] s;
        logic [15:0] lim;
        report_t     r;
        burst.delete();
        case (op)
            OP_SEND: begin
                eff = (window_reg < 5'd1) ? 1 : int'(window_reg);
                if (eff > DEPTH) eff = DEPTH;
                if (eff > 16) eff = 16;
                s = next_q;
                if (32'(next_q - base_q) < 32'(eff)) begin
                    k = slot_idx(s);
                    pend[k]  = 1'b1;
                    acked[k] = 1'b0;
                    age[k]   = '0;
                    next_q   = s + 32'd1;
                    note(K_SENT, s);
                end else begin
                    note(K_FULL, s);
                end
            end
            OP_ACK: begin
                if (crc32_word(num) != crc) begin
                    note(K_ACK_BAD, num);
                end else if (32'(num - base_q) >= 32'(next_q - base_q)) begin
                    note(K_ACK_OUT, num);
                end else begin
                    acked[slot_idx(num)] = 1'b1;
                    // release the leading acked slots
                    while (base_q != next_q && acked[slot_idx(base_q)]) begin
                        k = slot_idx(base_q);
                        pend[k]  = 1'b0;
                        acked[k] = 1'b0;
                        age[k]   = '0;
                        base_q   = base_q + 32'd1;
                    end
                    note(K_ACK_OK, num);
                end
            end
            OP_TICK: begin
                lim = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
                s = base_q;
                while (s != next_q && burst.size() < 16) begin
                    k = slot_idx(s);
                    if (pend[k] && !acked[k]) begin
                        if (age[k] != 16'hFFFF) age[k] = age[k] + 16'd1;
                        if (age[k] >= lim) begin
                            age[k] = '0;
                            note(K_RETX, s);
                        end
                    end
                    s = s + 32'd1;
                end
                if (burst.size() == 0) note(K_IDLE, base_q);
            end
            default: ;
        endcase
        if (burst.size() > 0) begin
            r = burst.pop_back();
            r.last = 1'b1;
            burst.push_back(r);
            foreach (burst[i]) awaited_reports.push_back(burst[i]);
        end
    endtask

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        report_t want;
        int      miss;
        if (!aresetn) begin
            base_q      = '0;
            next_q      = '0;
            timeout_reg = TIMEOUT_RST;
            window_reg  = WINDOW_RST;
            fails       = 0;
            for (int i = 0; i < DEPTH; i++) begin
                pend[i]  = 1'b0;
                acked[i] = 1'b0;
                age[i]   = '0;
            end
            awaited_reports.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TIMEOUT) begin
                    timeout_reg = cfg_wdata;
                end else if (cfg_index == CFG_WINDOW) begin
                    window_reg = cfg_wdata[4:0];
                end
            end
            if (s_tvalid && s_tready) begin
                advance_window(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual kind %0h data %0h",
                             $time, m_tuser, m_tdata);
                    fails++;
                end else begin
                    want = awaited_reports.pop_front();
                    miss = field_bad("kind", 32'(want.kind), 32'(m_tuser))
                         + field_bad("seq", want.seq, m_tdata[31:0])
                         + field_bad("slot", 32'(want.slot), 32'(m_tdata[35:32]))
                         + field_bad("base_seq", want.base, m_tdata[67:36])
                         + field_bad("in_flight", 32'(want.flight), 32'(m_tdata[72:68]))
                         + field_bad("last", 32'(want.last), 32'(m_tlast));
                    fails += miss;
                end
            end
        end
        pending    <= awaited_reports.size();
        win_base   <= base_q;
        win_next   <= next_q;
        fail_count <= fails;
    end

endmodule

// File: test/tb_selective_repeat_sender_window.sv
// testbench top for the selective-repeat sender window: clock, reset,
// stimulus, result-side flow control, watchdog and verdict
// depends on srsw_pkg, srsw_tb_pkg, srsw_checker and the block itself
module tb_selective_repeat_sender_window;
    import srsw_pkg::*;
    import srsw_tb_pkg::*;

    localparam int DEPTH       = 16;
    localparam int QUIET_LIMIT = 4000;  // cycles without any transfer
    localparam int DRAIN       = 64;    // covers the longest tick or ack walk
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS = 56;
    localparam int N_PHASES    = 8;

    // settings walked through after the directed part, extremes included
    localparam logic [15:0] TMO_SET [0:N_PHASES-1] =
        '{16'd2, 16'd0, 16'd1, 16'd65535, 16'd3, 16'd1, 16'd7, 16'd4};
    localparam logic [15:0] WIN_SET [0:N_PHASES-1] =
        '{16'd16, 16'd1, 16'd31, 16'd0, 16'd4, 16'd16, 16'd10, 16'd8};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tlast;
    logic [KIND_W-1:0]     m_tuser;
    logic [M_DATA_W-1:0]   m_tdata;

    int          fail_count;
    int          pending;
    logic [31:0] win_base;
    logic [31:0] win_next;
    int          quiet = 0;

    // knobs shared between the stimulus and the receiver
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit rx_hold = 1'b0;

    always #1 aclk = ~aclk;

    selective_repeat_sender_window #(
        .WINDOW_DEPTH(DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),    // op
        .s_tdata   (s_tdata),    // ack_number, ack_crc
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),    // kind
        .m_tdata   (m_tdata)     // seq, slot, base_seq, in_flight, zero pad
    );

    srsw_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .win_base   (win_base),
        .win_next   (win_next)
    );

    // watchdog: ends the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("selective_repeat_sender_window test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result side: ready stretches broken by short and rare long stalls,
    // plus one long hold-off on request so the block backs up into its input
    initial begin : receiver
        int n;
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // idle cycles before the next input transfer, mostly none or short
    function automatic int pick_gap();
        int r;
        if (!tx_gaps) return 0;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one input transfer; valid stays high when the next one follows at once
    task automatic offer(op_t op, logic [31:0] num, logic [31:0] crc, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {crc, num};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // random input: sends, mostly well-formed acks inside the window, ticks,
    // and now and then an unused op that the block ignores
    task automatic random_item(output bit counted);
        int          r;
        int          a;
        logic [31:0] num;
        logic [31:0] crc;
        logic [31:0] flight;
        r = $urandom_range(0, 99);
        num = $urandom;
        crc = $urandom;
        counted = 1'b1;
        if (r < 3) begin
            offer(OP_NONE, num, crc, pick_gap());
            counted = 1'b0;
        end else if (r < 40) begin
            offer(OP_SEND, num, crc, pick_gap());
        end else if (r < 72) begin
            flight = win_next - win_base;
            a = $urandom_range(0, 19);
            if (a < 15) begin
                // in window or one past its end
                num = win_base + $urandom_range(0, flight);
                crc = crc32_word(num);
            end else if (a < 16) begin
                num = win_base - 32'd1;
                crc = crc32_word(num);
            end else if (a < 18) begin
                crc = crc32_word(num);
            end else if (a < 19) begin
                num = win_base + $urandom_range(0, flight);
                crc = crc32_word(num) ^ (32'd1 << $urandom_range(0, 31));
            end
            offer(OP_ACK, num, crc, pick_gap());
        end else begin
            offer(OP_TICK, num, crc, pick_gap());
        end
    endtask

    initial begin : stimulus
        int done;
        bit counted;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the reset settings (timeout 1000, window 10)
        offer(OP_TICK, 32'h0, 32'h0, 0);                    // idle tick, empty window
        offer(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);    // ignored op
        for (int i = 0; i < 11; i++) begin
            // ten sends fill the window, the eleventh is refused
            offer(OP_SEND, (i % 2) ? 32'hFFFF_FFFF : 32'h0,
                  (i % 2) ? 32'h0 : 32'hFFFF_FFFF, 0);
        end
        offer(OP_ACK, 32'd3, crc32_word(32'd3), 0);         // ack ok, no slide
        offer(OP_ACK, 32'd3, crc32_word(32'd3), 0);         // duplicate ack
        offer(OP_ACK, 32'd0, crc32_word(32'd0), 0);         // base slides by one
        offer(OP_ACK, 32'd1, crc32_word(32'd1) ^ 32'h8000_0000, 0); // bad crc
        offer(OP_ACK, 32'd20, crc32_word(32'd20), 0);       // beyond next
        offer(OP_ACK, 32'hFFFF_FFFF, crc32_word(32'hFFFF_FFFF), 0); // below base
        offer(OP_ACK, 32'd0, 32'd0, 0);                     // bad crc, zero word
        offer(OP_ACK, 32'd0, crc32_word(32'd0), 0);         // already released
        offer(OP_ACK, 32'd1, crc32_word(32'd1), 0);         // base to 2
        offer(OP_ACK, 32'd2, crc32_word(32'd2), 0);         // slides over 2 and 3
        offer(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);    // idle, far from timeout
        settle();

        // random phases, each under its own settings and idling mix
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_TIMEOUT, TMO_SET[p]);
            write_reg(CFG_WINDOW, WIN_SET[p]);
            tx_gaps = (p % 3 != 1);
            rx_gaps = (p % 3 != 2);
            if (p == 1 || p == 4) rx_hold = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_item(counted);
                if (counted) done++;
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("selective_repeat_sender_window test passed");
        end else begin
            $display("selective_repeat_sender_window test failed");
        end
        $finish;
    end

endmodule
